// ----- hw/rtl/bre_pkg.sv -----
// Shared types and constants for the Exp-Golomb bitstream reader.
package bre_pkg;

	localparam int POS_W = 16;
	localparam int VAL_W = 32;
	localparam int CNT_W = 6;
	localparam int CFG_W = 13;

	typedef enum logic [2:0] {
		MODE_WRITE   = 3'd0,
		MODE_RESTART = 3'd1,
		MODE_READ    = 3'd2,
		MODE_PEEK    = 3'd3,
		MODE_SKIP    = 3'd4,
		MODE_UE      = 3'd5,
		MODE_SE      = 3'd6,
		MODE_NOP     = 3'd7
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] bit_count;
		logic [11:0] byte_address;
		logic [7:0]  byte_data;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        value;
		logic signed [31:0] signed_value;
		logic               error;
		logic [15:0]        bits_left;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic mem_write;
		logic restart;
		logic skip;
		logic set_err;
		logic rw_init;
		logic ue_init;
		logic load;
		logic step_zero;
		logic step_one;
		logic suffix_init;
		logic step_shift;
		logic finish;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  short_rw;
		logic  z_at_limit;
		logic  have;
		logic  bit_val;
		logic  suffix_short;
		logic  cnt_zero;
	} sts_t;

endpackage

// ----- hw/rtl/bre_ctrl.sv -----
// Controller state machine that sequences each word through the datapath.
module bre_ctrl import bre_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DISP  = 6'b000010,
		S_ZSCAN = 6'b000100,
		S_ZEND  = 6'b001000,
		S_SHIFT = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			done_q  <= (state_q == S_DONE);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_next  = S_DISP;
				end
			end
			S_DISP: begin
				state_next = S_DONE;
				case (sts.mode)
					MODE_WRITE: begin
						cmd.mem_write = 1'b1;
					end
					MODE_RESTART: begin
						cmd.restart = 1'b1;
					end
					MODE_SKIP: begin
						cmd.skip = 1'b1;
					end
					MODE_READ, MODE_PEEK: begin
						if (sts.short_rw) begin
							cmd.set_err = 1'b1;
						end else begin
							cmd.rw_init = 1'b1;
							state_next  = S_SHIFT;
						end
					end
					MODE_UE, MODE_SE: begin
						cmd.ue_init = 1'b1;
						state_next  = S_ZSCAN;
					end
					default: begin
						state_next = S_DONE;
					end
				endcase
			end
			S_ZSCAN: begin
				if (sts.z_at_limit) begin
					cmd.set_err = 1'b1;
					state_next  = S_DONE;
				end else if (!sts.have) begin
					cmd.load = 1'b1;
				end else if (sts.bit_val) begin
					cmd.step_one = 1'b1;
					state_next   = S_ZEND;
				end else begin
					cmd.step_zero = 1'b1;
				end
			end
			S_ZEND: begin
				if (sts.suffix_short) begin
					cmd.set_err = 1'b1;
					state_next  = S_DONE;
				end else begin
					cmd.suffix_init = 1'b1;
					state_next      = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (sts.cnt_zero) begin
					state_next = S_DONE;
				end else if (!sts.have) begin
					cmd.load = 1'b1;
				end else begin
					cmd.step_shift = 1'b1;
				end
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_next = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/bre_dp.sv -----
// Datapath with byte store, read position, bit shifter and result registers.
module bre_dp import bre_pkg::*; #(
	parameter int BUF_BYTES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  in_item_t         item,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	output out_item_t        result
);

	localparam int AW = $clog2(BUF_BYTES);
	localparam logic [16:0] BUF_LIM = 17'(BUF_BYTES);

	logic [7:0] mem [BUF_BYTES];

	in_item_t         item_q;
	logic [CFG_W-1:0] byte_count_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] cur_q;
	logic             err_q;
	logic             fail_q;
	logic             have_q;
	logic [CNT_W-1:0] z_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] acc_q;
	logic [7:0]       rd_q;
	logic [VAL_W-1:0] value_q;
	logic [VAL_W-1:0] sval_q;

	logic [CFG_W-1:0]  eff_count;
	logic [POS_W-1:0]  total;
	logic [POS_W-1:0]  left;
	logic [POS_W-1:0]  n;
	logic [CNT_W-1:0]  k;
	logic [CNT_W-1:0]  limit;
	logic [AW+15:0]    cur_ext;
	logic [AW-1:0]     rd_addr;
	logic [AW+11:0]    wr_ext;
	logic [AW-1:0]     wr_addr;
	logic              wr_ok;
	logic              bit_sel;
	logic [VAL_W-1:0]  code;
	logic [VAL_W-1:0]  half;
	logic [VAL_W-1:0]  se_val;
	logic [POS_W-1:0]  ue_len;
	logic              byte_more;

	assign eff_count = ({4'b0, byte_count_q} > BUF_LIM) ? BUF_LIM[CFG_W-1:0] : byte_count_q;
	assign total     = {eff_count, 3'b000};
	assign left      = (total > pos_q) ? (total - pos_q) : '0;
	assign n         = item_q.bit_count;
	assign k         = (n < 16'd32) ? n[CNT_W-1:0] : 6'd32;
	assign limit     = (left < 16'd32) ? left[CNT_W-1:0] : 6'd32;
	assign cur_ext   = {{AW{1'b0}}, cur_q};
	assign rd_addr   = cur_ext[AW+2:3];
	assign wr_ext    = {{AW{1'b0}}, item_q.byte_address};
	assign wr_addr   = wr_ext[AW-1:0];
	assign wr_ok     = ({5'b0, item_q.byte_address} < BUF_LIM);
	assign bit_sel   = rd_q[3'd7 - cur_q[2:0]];
	assign code      = acc_q - 32'd1;
	assign half      = {1'b0, code[31:1]};
	assign se_val    = code[0] ? (half + 32'd1) : (32'd0 - half);
	assign ue_len    = {9'b0, z_q, 1'b1};
	assign byte_more = (cur_q[2:0] != 3'b111);

	assign sts.mode         = item_q.mode;
	assign sts.short_rw     = (left < n);
	assign sts.z_at_limit   = (z_q == limit);
	assign sts.have         = have_q;
	assign sts.bit_val      = bit_sel;
	assign sts.suffix_short = (ue_len > left);
	assign sts.cnt_zero     = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.mem_write && wr_ok) begin
			mem[wr_addr] <= item_q.byte_data;
		end
		if (cmd.load) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			pos_q        <= '0;
			err_q        <= 1'b0;
			fail_q       <= 1'b0;
			have_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				byte_count_q <= cfg_data;
			end
			if (cmd.restart) begin
				pos_q <= '0;
				err_q <= 1'b0;
			end else if (cmd.skip) begin
				pos_q <= pos_q + ((n > left) ? left : n);
			end else if (cmd.finish && !fail_q) begin
				if (item_q.mode == MODE_READ) begin
					pos_q <= pos_q + n;
				end else if (item_q.mode == MODE_UE || item_q.mode == MODE_SE) begin
					pos_q <= pos_q + ue_len;
				end
			end
			if (cmd.set_err) begin
				err_q  <= 1'b1;
				fail_q <= 1'b1;
			end else if (cmd.capture) begin
				fail_q <= 1'b0;
			end
			if (cmd.rw_init || cmd.ue_init) begin
				have_q <= 1'b0;
			end else if (cmd.load) begin
				have_q <= 1'b1;
			end else if (cmd.step_zero || cmd.step_one || cmd.step_shift) begin
				have_q <= byte_more;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.rw_init) begin
			cur_q <= pos_q + n - 16'(k);
			cnt_q <= k;
			acc_q <= '0;
		end else if (cmd.ue_init) begin
			cur_q <= pos_q;
			z_q   <= '0;
			acc_q <= 32'd1;
		end else if (cmd.step_zero) begin
			z_q   <= z_q + 6'd1;
			cur_q <= cur_q + 16'd1;
		end else if (cmd.step_one) begin
			cur_q <= cur_q + 16'd1;
		end else if (cmd.suffix_init) begin
			cnt_q <= z_q;
		end else if (cmd.step_shift) begin
			acc_q <= {acc_q[30:0], bit_sel};
			cur_q <= cur_q + 16'd1;
			cnt_q <= cnt_q - 6'd1;
		end
		if (cmd.finish) begin
			if (fail_q) begin
				value_q <= '0;
			end else if (item_q.mode == MODE_READ || item_q.mode == MODE_PEEK) begin
				value_q <= acc_q;
			end else if (item_q.mode == MODE_UE || item_q.mode == MODE_SE) begin
				value_q <= code;
			end else begin
				value_q <= '0;
			end
			sval_q <= (!fail_q && item_q.mode == MODE_SE) ? se_val : '0;
		end
	end

	assign result.value        = value_q;
	assign result.signed_value = $signed(sval_q);
	assign result.error        = err_q;
	assign result.bits_left    = left;

endmodule

// ----- hw/rtl/bitstream_reader_exp_golomb.sv -----
// Top level of the MSB-first bit reader with Exp-Golomb decoding.
//
// A word is taken at a rising edge where start is high and busy is low. Its
// result appears on result, with done high for a single cycle; the
// receiver cannot stall and must take the result in that cycle, which the
// block itself does not enforce. The byte_count register is written over
// cfg_valid/cfg_ready/cfg_data, with cfg_ready high whenever busy is low.
// Write byte, restart, skip, no-op words and failed reads or peeks pass
// from dispatch straight to the done state, and the next word can be taken
// in the done cycle; no new word is taken while one is still in progress.
// Reads and peeks of k kept bits pass through dispatch, shift and done;
// ue or se codes with z leading zeros add a zero scan and a suffix check
// before the shift of z bits. Bits shift at one per cycle, pausing for
// each byte load; the byte store gives one registered byte read per cycle.
// Reset clears the read position, the sticky error and byte_count; the
// byte store holds no defined contents until written.
module bitstream_reader_exp_golomb import bre_pkg::*; #(
	parameter int BUF_BYTES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_item_t         item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	output logic             done,
	output out_item_t        result
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = ~busy;

	bre_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	bre_dp #(
		.BUF_BYTES (BUF_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.item     (item),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.result   (result)
	);

endmodule

// ----- hw/rtl/bre_chk.sv -----
// Port-level checker for the bitstream reader and its bind statement.
module bre_chk import bre_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input out_item_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("Accepted word did not raise busy.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result strobe while busy.");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe lasted more than one cycle.");

	a_se_code: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.signed_value != 0) |-> (result.value != 0))
		else $error("Nonzero signed value with zero code number.");

endmodule

bind bitstream_reader_exp_golomb bre_chk u_bre_chk (.*);
